// ===== hw/rtl/atan2_pkg.sv =====
// ----------------------------------------------------------------------------
// atan2_pkg: shared constants and types
// Coefficients, angle constants and the request record for the atan2 block.
// ----------------------------------------------------------------------------
package atan2_pkg;

  localparam int DivSteps = 31;
  localparam int PolyStages = 7;

  localparam logic signed [31:0] C0 = 32'sd536890772;
  localparam logic signed [31:0] C1 = -32'sd178298711;
  localparam logic signed [31:0] C2 = 32'sd99794340;
  localparam logic signed [31:0] C3 = -32'sd49499604;
  localparam logic signed [31:0] C4 = 32'sd12781063;
  localparam logic signed [31:0] AngPi = 32'sd1686629713;
  localparam logic signed [31:0] AngHalfPi = 32'sd843314856;

  typedef struct packed {
    logic        origin;
    logic        steep;
    logic        xneg;
    logic        yneg;
  } flags_t;

  typedef struct packed {
    flags_t      flags;
    logic [30:0] num;
    logic [30:0] den;
  } req_t;

  function automatic logic signed [31:0] mul_shift(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[62:31];
  endfunction

endpackage

// ===== hw/rtl/atan2_front.sv =====
// ----------------------------------------------------------------------------
// atan2_front: input classification
// Takes magnitudes, orders them by size and registers the request.
// ----------------------------------------------------------------------------
module atan2_front import atan2_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] in_y_imag,
  input  logic signed [31:0] in_x_real,
  output logic               req_vld,
  output req_t               req
);

  logic [30:0] ax, ay;
  logic        vld_r;
  req_t        req_r, req_nxt;

  always_comb begin
    ax = (in_x_real == 32'sh80000000) ? 31'h7fffffff :
         (in_x_real[31] ? 31'(-in_x_real) : in_x_real[30:0]);
    ay = (in_y_imag == 32'sh80000000) ? 31'h7fffffff :
         (in_y_imag[31] ? 31'(-in_y_imag) : in_y_imag[30:0]);
    req_nxt.flags.origin = (in_x_real == 32'sd0) && (in_y_imag == 32'sd0);
    req_nxt.flags.steep = ay > ax;
    req_nxt.flags.xneg = in_x_real[31];
    req_nxt.flags.yneg = in_y_imag[31];
    req_nxt.num = (ay > ax) ? ax : ay;
    req_nxt.den = (ay > ax) ? ay : ax;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start;
    end
    req_r <= req_nxt;
  end

  assign req_vld = vld_r;
  assign req = req_r;

endmodule

// ===== hw/rtl/atan2_div.sv =====
// ----------------------------------------------------------------------------
// atan2_div: pipelined restoring divider
// One quotient bit per stage gives the ratio z of the two magnitudes.
// ----------------------------------------------------------------------------
module atan2_div import atan2_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_vld,
  input  req_t               req,
  output logic               z_vld,
  output logic signed [31:0] z,
  output flags_t             z_flags
);

  logic [DivSteps:0]      vld_r;
  logic [31:0]            rem_r [DivSteps+1];
  logic [30:0]            den_r [DivSteps+1];
  logic [30:0]            q_r   [DivSteps+1];
  flags_t                 fl_r  [DivSteps+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DivSteps-1:0], req_vld};
    end
    rem_r[0] <= {1'b0, req.num};
    den_r[0] <= req.den;
    q_r[0] <= '0;
    fl_r[0] <= req.flags;
    for (int i = 0; i < DivSteps; i++) begin
      logic [32:0] t;
      t = {rem_r[i], 1'b0};
      if (t >= {2'b0, den_r[i]}) begin
        rem_r[i+1] <= 32'(t - {2'b0, den_r[i]});
        q_r[i+1] <= {q_r[i][29:0], 1'b1};
      end else begin
        rem_r[i+1] <= t[31:0];
        q_r[i+1] <= {q_r[i][29:0], 1'b0};
      end
      den_r[i+1] <= den_r[i];
      fl_r[i+1] <= fl_r[i];
    end
  end

  // Quotient reaches 2^31 only when num equals den; it then saturates.
  always_comb begin
    z_vld = vld_r[DivSteps];
    z_flags = fl_r[DivSteps];
    if ((rem_r[DivSteps] != '0) && (rem_r[DivSteps] >= {1'b0, den_r[DivSteps]}))
      z = 32'sh7fffffff;
    else
      z = {1'b0, q_r[DivSteps]};
  end

endmodule

// ===== hw/rtl/atan2_poly.sv =====
// ----------------------------------------------------------------------------
// atan2_poly: polynomial and quadrant fold
// Horner evaluation, one multiply per stage, then octant and quadrant fix.
// ----------------------------------------------------------------------------
module atan2_poly import atan2_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               z_vld,
  input  logic signed [31:0] z,
  input  flags_t             z_flags,
  output logic               out_strobe,
  output logic signed [31:0] out_angle
);

  logic [PolyStages-1:0] vld_r;
  logic signed [31:0] z_r   [PolyStages];
  logic signed [31:0] z2_r  [PolyStages];
  logic signed [31:0] acc_r [PolyStages];
  flags_t             fl_r  [PolyStages];
  logic signed [31:0] ang, a1, a2;
  logic signed [31:0] ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PolyStages-2:0], z_vld};
    end
    z_r[0] <= z;
    z2_r[0] <= mul_shift(z, z);
    acc_r[0] <= '0;
    fl_r[0] <= z_flags;
    for (int i = 1; i < PolyStages; i++) begin
      z_r[i] <= z_r[i-1];
      z2_r[i] <= z2_r[i-1];
      fl_r[i] <= fl_r[i-1];
    end
    acc_r[1] <= mul_shift(z2_r[0], C4) + C3;
    acc_r[2] <= mul_shift(z2_r[1], acc_r[1]) + C2;
    acc_r[3] <= mul_shift(z2_r[2], acc_r[2]) + C1;
    acc_r[4] <= mul_shift(z2_r[3], acc_r[3]) + C0;
    acc_r[5] <= mul_shift(z_r[4], acc_r[4]);
    acc_r[6] <= acc_r[5];
    ang_r <= ang;
  end

  always_comb begin
    a1 = fl_r[5].steep ? AngHalfPi - acc_r[5] : acc_r[5];
    a2 = fl_r[5].xneg ? AngPi - a1 : a1;
    ang = fl_r[5].yneg ? -a2 : a2;
    if (fl_r[5].origin)
      ang = '0;
  end

  assign out_strobe = vld_r[6];
  assign out_angle = ang_r;

endmodule

// ===== hw/rtl/atan2_q31_polynomial.sv =====
// ----------------------------------------------------------------------------
// atan2_q31_polynomial: four-quadrant arctangent, Q1.31 in, Q3.29 out
// Front classification, pipelined divider and Horner polynomial.
// ----------------------------------------------------------------------------
// One request is taken every cycle (busy stays low) and each angle appears on
// out_angle with out_strobe for one cycle, after passing through one front
// stage, 32 divider stages (a load stage and 31 stages at one quotient bit
// each), and seven polynomial and fold stages. The receiver cannot stall;
// results are issued in request order.
module atan2_q31_polynomial import atan2_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_y_imag,
  input  logic signed [31:0] in_x_real,
  output logic               out_strobe,
  output logic signed [31:0] out_angle
);

  logic               req_vld, z_vld;
  req_t               req;
  logic signed [31:0] z;
  flags_t             z_flags;

  assign busy = 1'b0;

  atan2_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start),
    .in_y_imag(in_y_imag), .in_x_real(in_x_real),
    .req_vld(req_vld), .req(req)
  );

  atan2_div u_div (
    .clk(clk), .rst_n(rst_n), .req_vld(req_vld), .req(req),
    .z_vld(z_vld), .z(z), .z_flags(z_flags)
  );

  atan2_poly u_poly (
    .clk(clk), .rst_n(rst_n), .z_vld(z_vld), .z(z), .z_flags(z_flags),
    .out_strobe(out_strobe), .out_angle(out_angle)
  );

endmodule

// ===== tb/sv/atan2_q31_polynomial_tb.sv =====
// ----------------------------------------------------------------------------
// atan2_q31_polynomial_tb: self-checking bench for the atan2 block
// Drives Q1.31 points through the command port, with and without random
// sender gaps, predicts each Q3.29 angle with a bit-exact model and checks
// the results in request order through a small scoreboard.
// ----------------------------------------------------------------------------
module atan2_q31_polynomial_tb;
  import atan2_pkg::*;

  localparam int WatchLimit = 2000;
  localparam int DrainCycles = 60;

  class angle_board;
    logic signed [31:0] pending[$];
    int mismatches;

    static function logic signed [31:0] mulsh(logic signed [31:0] a,
                                               logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      p = p >>> 31;
      return p[31:0];
    endfunction

    static function logic [31:0] magnitude(logic signed [31:0] v);
      if (v >= 0) return v;
      if (v == 32'sh80000000) return 32'h7fffffff;
      return -v;
    endfunction

    static function logic signed [31:0] predict_angle(logic signed [31:0] y,
                                                      logic signed [31:0] x);
      logic [31:0] ax, ay, num, den;
      logic [63:0] q;
      logic signed [31:0] z, z2, acc, ang;
      logic steep;
      if (x == 0 && y == 0) return 0;
      ax = magnitude(x);
      ay = magnitude(y);
      steep = ay > ax;
      num = steep ? ax : ay;
      den = steep ? ay : ax;
      q = {1'b0, num, 31'b0} / {32'b0, den};
      if (q > 64'h7fffffff) q = 64'h7fffffff;
      z = q[31:0];
      z2 = mulsh(z, z);
      acc = mulsh(z2, C4) + C3;
      acc = mulsh(z2, acc) + C2;
      acc = mulsh(z2, acc) + C1;
      acc = mulsh(z2, acc) + C0;
      ang = mulsh(z, acc);
      if (steep) ang = AngHalfPi - ang;
      if (x < 0) begin
        ang = AngPi - ang;
        if (y < 0) ang = -ang;
      end else if (y < 0) begin
        ang = -ang;
      end
      return ang;
    endfunction

    function void note_request(logic signed [31:0] y, logic signed [31:0] x);
      pending.push_back(predict_angle(y, x));
    endfunction

    function void check_angle(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected angle %0d", got);
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("angle mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_strobe;
  logic signed [31:0] in_y_imag, in_x_real, out_angle;
  angle_board board;
  int idle_pct;
  int quiet;

  atan2_q31_polynomial dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_y_imag(in_y_imag), .in_x_real(in_x_real),
    .out_strobe(out_strobe), .out_angle(out_angle)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_angle(out_angle);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("atan2_q31_polynomial_tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 0;
      3: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_point(logic signed [31:0] y, logic signed [31:0] x);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_y_imag <= y;
    in_x_real <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(y, x);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(int count);
    logic signed [31:0] y, x;
    for (int i = 0; i < count; i++) begin
      y = pick_value();
      x = pick_value();
      if ($urandom_range(0, 9) == 0) x = ($urandom_range(0, 1) ? y : -y);
      if ($urandom_range(0, 19) == 0) x = 0;
      if ($urandom_range(0, 19) == 0) y = 0;
      send_point(y, x);
    end
  endtask

  initial begin
    logic signed [31:0] ext[5];
    board = new();
    quiet = 0;
    rst_n = 0;
    start = 0;
    in_y_imag = 0;
    in_x_real = 0;
    idle_pct = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;
    ext = '{32'sh80000000, 32'sh7fffffff, 0, 1, -1};
    foreach (ext[i]) begin
      foreach (ext[j]) send_point(ext[i], ext[j]);
    end
    wait_drained();
    idle_pct = 29;
    send_random(200);
    wait_drained();
    idle_pct = 85;
    send_random(200);
    idle_pct = 0;
    send_random(200);
    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("atan2_q31_polynomial_tb OK");
    end else begin
      $display("atan2_q31_polynomial_tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/atan2_pkg.sv
hw/rtl/atan2_front.sv
hw/rtl/atan2_div.sv
hw/rtl/atan2_poly.sv
hw/rtl/atan2_q31_polynomial.sv
tb/sv/atan2_q31_polynomial_tb.sv
